>>> sv/clns_pkg.sv
// Shared types and codes for the character LCD nibble sequencer.
// No dependencies; compiled first.
package clns_pkg;

  // Text buffer geometry
  localparam int BufChars = 16;
  localparam int BufIdxW  = $clog2(BufChars);
  localparam int LenW     = 5;
  localparam int CntW     = 7;

  localparam logic [CntW-1:0] PowerUpTicks = CntW'(100);
  localparam logic [3:0]      LinesReset   = 4'h8;

  // Command codes
  localparam logic [2:0] OpTick    = 3'd0;
  localparam logic [2:0] OpInit    = 3'd1;
  localparam logic [2:0] OpLoad    = 3'd2;
  localparam logic [2:0] OpWrite   = 3'd3;
  localparam logic [2:0] OpClear   = 3'd4;
  localparam logic [2:0] OpGoto    = 3'd5;
  localparam logic [2:0] OpCursor  = 3'd6;
  localparam logic [2:0] OpDisplay = 3'd7;

  // Running sequence
  localparam logic [2:0] SeqIdle  = 3'd0;
  localparam logic [2:0] SeqInit  = 3'd1;
  localparam logic [2:0] SeqWrite = 3'd2;
  localparam logic [2:0] SeqClear = 3'd3;
  localparam logic [2:0] SeqGoto  = 3'd4;
  localparam logic [2:0] SeqSetup = 3'd5;

  // Init phases
  localparam logic [2:0] PhWait    = 3'd0;
  localparam logic [2:0] PhSpecial = 3'd1;
  localparam logic [2:0] PhFset    = 3'd2;
  localparam logic [2:0] PhDisplay = 3'd3;
  localparam logic [2:0] PhClear   = 3'd4;
  localparam logic [2:0] PhEntry   = 3'd5;

  typedef struct packed {
    logic [2:0]      op;
    logic [7:0]      char_code;
    logic [3:0]      char_index;
    logic [LenW-1:0] length;
    logic [5:0]      column;
    logic            row;
    logic            cursor_on;
    logic            blink_on;
    logic            display_on;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       busy_res;
    logic       initialized;
    logic       done_res;
    logic       reg_select;
    logic       enable;
    logic [3:0] data_pins;
  } out_item_t;

  typedef struct packed {
    logic               en;
    logic [BufIdxW-1:0] idx;
    logic [7:0]         data;
  } buf_wr_t;

endpackage

>>> sv/clns_ifs.sv
// Valid/ready channel interfaces for the LCD nibble sequencer.
// Depends on clns_pkg.
interface clns_in_if;
  logic               valid;
  logic               ready;
  clns_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface clns_out_if;
  logic                valid;
  logic                ready;
  clns_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface clns_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/char_lcd_nibble_sequencer.sv
// Top level of the 4-bit character LCD sequencer: handshake and result register.
// Depends on clns_pkg, clns_ifs, clns_text_buf and clns_core.
//
// Usage: every transfer on in_i is one tick (op 0) or one command; each gives
// exactly one result on out_o carrying the handshake status (accepted, busy,
// initialized, done) and the pin levels after that step. Run init first; other
// commands are ignored (accepted low) until init completes or while busy.
// A result appears on out_o the cycle after its input transfer.
// Throughput is one item per cycle; the single result register is
// refilled in the same cycle it is taken, so in_i.ready stays high while
// out_o.ready is high. If the receiver stalls, the result holds and in_i.ready
// drops until it is taken. cfg_i writes lines_setting at any time (always
// ready); write it only while the sequencer is idle.
// Reset: sequencer idle, not initialized, pins and enable low, lines_setting 8.
// The text buffer has no reset; send only slots that were loaded.
module char_lcd_nibble_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  clns_in_if.sink           in_i,
  clns_cfg_if.sink          cfg_i,
  clns_out_if.source        out_o
);
  import clns_pkg::*;

  logic               step;
  out_item_t          res;
  buf_wr_t            buf_wr;
  logic [BufIdxW-1:0] buf_rd_idx;
  logic [7:0]         buf_rd_data;
  logic               out_valid_q;
  out_item_t          out_data_q;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign step        = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  clns_text_buf u_buf (
    .clk_i     (clk_i),
    .wr_i      (buf_wr),
    .rd_idx_i  (buf_rd_idx),
    .rd_data_o (buf_rd_data)
  );

  clns_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .item_i        (in_i.data),
    .cfg_we_i      (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .res_o         (res),
    .buf_wr_o      (buf_wr),
    .buf_rd_idx_o  (buf_rd_idx),
    .buf_rd_data_i (buf_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

>>> sv/clns_text_buf.sv
// Character buffer: one write port, one registered read port.
// Depends on clns_pkg.
module clns_text_buf (
  input  logic                        clk_i,
  input  clns_pkg::buf_wr_t           wr_i,
  input  logic [clns_pkg::BufIdxW-1:0] rd_idx_i,
  output logic [7:0]                  rd_data_o
);
  import clns_pkg::*;

  logic [7:0] mem_q [BufChars];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_idx_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/clns_core.sv
// Sequencer state and its next-state logic; produces the result of each transfer.
// Depends on clns_pkg.
module clns_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  clns_pkg::in_item_t          item_i,
  input  logic                        cfg_we_i,
  input  logic [3:0]                  cfg_data_i,
  output clns_pkg::out_item_t         res_o,
  output clns_pkg::buf_wr_t           buf_wr_o,
  output logic [clns_pkg::BufIdxW-1:0] buf_rd_idx_o,
  input  logic [7:0]                  buf_rd_data_i
);
  import clns_pkg::*;

  logic [3:0]      lines_q;
  logic [2:0]      seq_q, seq_d;
  logic [2:0]      ph_q, ph_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            en_q, en_d;
  logic            wph_q, wph_d;
  logic [LenW-1:0] cpos_q, cpos_d;
  logic [3:0]      dctl_q, dctl_d;
  logic            init_q, init_d;
  logic [LenW-1:0] tlen_q, tlen_d;
  logic [7:0]      taddr_q, taddr_d;
  logic            rs_q, rs_d;
  logic [3:0]      pins_q, pins_d;

  logic            snd, snd_rs;
  logic [3:0]      snd_nib;
  logic            done, acc, idle;
  logic [CntW-1:0] c;
  logic [3:0]      cursor_ctl;
  logic [7:0]      addr;

  assign idle       = (seq_q == SeqIdle);
  assign c          = cnt_q;
  assign cursor_ctl = {2'b11, item_i.cursor_on, item_i.blink_on};
  assign addr       = {1'b1, item_i.row, item_i.column};

  // buffer read is registered: fetch the slot that the next step will use
  assign buf_rd_idx_o  = step_i ? cpos_d[BufIdxW-1:0] : cpos_q[BufIdxW-1:0];
  assign buf_wr_o.en   = step_i && (item_i.op == OpLoad) && idle && init_q &&
                         ({1'b0, item_i.char_index} < 5'(BufChars));
  assign buf_wr_o.idx  = BufIdxW'(item_i.char_index);
  assign buf_wr_o.data = item_i.char_code;

  always_comb begin
    seq_d   = seq_q;
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    en_d    = en_q;
    wph_d   = wph_q;
    cpos_d  = cpos_q;
    dctl_d  = dctl_q;
    init_d  = init_q;
    tlen_d  = tlen_q;
    taddr_d = taddr_q;
    snd     = 1'b0;
    snd_rs  = 1'b0;
    snd_nib = 4'h0;
    done    = 1'b0;
    acc     = 1'b0;

    if (item_i.op == OpTick) begin
      if (!idle) begin
        if (en_q) begin
          en_d = 1'b0;
        end else begin
          cnt_d = cnt_q + 1'b1;
          case (seq_q)
            SeqInit: begin
              if (ph_q == PhWait) begin
                if (cnt_q == PowerUpTicks) begin
                  // dummy strobe: enable level set, pin held low until this phase's first nibble
                  cnt_d = '0;
                  ph_d  = PhSpecial;
                  en_d  = 1'b1;
                end
              end else begin
                case (ph_q)
                  PhSpecial: begin
                    if (c == 7'd0 || c == 7'd5) begin
                      snd = 1'b1; snd_nib = 4'h3;
                    end else if (c == 7'd6) begin
                      snd = 1'b1; snd_nib = 4'h3; cnt_d = '0; ph_d = PhFset;
                    end
                  end
                  PhFset: begin
                    if (c == 7'd0 || c == 7'd1) begin
                      snd = 1'b1; snd_nib = 4'h2;
                    end else if (c == 7'd2) begin
                      snd = 1'b1; snd_nib = lines_q; cnt_d = '0; ph_d = PhDisplay;
                    end
                  end
                  PhDisplay: begin
                    if (c == 7'd0) begin
                      snd = 1'b1; snd_nib = 4'h0;
                    end else if (c == 7'd1) begin
                      snd = 1'b1; snd_nib = dctl_q; cnt_d = '0; ph_d = PhClear;
                    end
                  end
                  PhClear: begin
                    if (c == 7'd0) begin
                      snd = 1'b1; snd_nib = 4'h0;
                    end else if (c == 7'd1) begin
                      snd = 1'b1; snd_nib = 4'h1;
                    end else if (c == 7'd3) begin
                      cnt_d = '0; ph_d = PhEntry;
                    end
                  end
                  default: begin
                    if (c == 7'd0) begin
                      snd = 1'b1; snd_nib = 4'h0;
                    end else if (c == 7'd1) begin
                      snd = 1'b1; snd_nib = 4'h6;
                    end else if (c == 7'd2) begin
                      ph_d = PhWait; init_d = 1'b1;
                      cnt_d = '0; seq_d = SeqIdle; done = 1'b1;
                    end
                  end
                endcase
              end
            end
            SeqWrite: begin
              if (!wph_q) begin
                if (c == 7'd0) begin
                  snd = 1'b1; snd_nib = taddr_q[7:4];
                end else if (c == 7'd1) begin
                  snd = 1'b1; snd_nib = taddr_q[3:0]; cnt_d = '0; wph_d = 1'b1;
                end
              end else if (cpos_q >= tlen_q || cpos_q >= LenW'(BufChars)) begin
                wph_d = 1'b0; cpos_d = '0;
                cnt_d = '0; seq_d = SeqIdle; done = 1'b1;
              end else if (c == 7'd0) begin
                snd = 1'b1; snd_rs = 1'b1; snd_nib = buf_rd_data_i[7:4];
              end else if (c == 7'd1) begin
                snd = 1'b1; snd_rs = 1'b1; snd_nib = buf_rd_data_i[3:0];
                cnt_d = '0; cpos_d = cpos_q + 1'b1;
              end
            end
            SeqClear: begin
              if (c == 7'd0) begin
                snd = 1'b1; snd_nib = 4'h0;
              end else if (c == 7'd1) begin
                snd = 1'b1; snd_nib = 4'h1;
              end else if (c == 7'd3) begin
                cnt_d = '0; seq_d = SeqIdle; done = 1'b1;
              end
            end
            SeqGoto: begin
              if (c == 7'd0) begin
                snd = 1'b1; snd_nib = taddr_q[7:4];
              end else if (c == 7'd1) begin
                snd = 1'b1; snd_nib = taddr_q[3:0];
              end else if (c == 7'd2) begin
                cnt_d = '0; seq_d = SeqIdle; done = 1'b1;
              end
            end
            default: begin
              if (c == 7'd0) begin
                snd = 1'b1; snd_nib = 4'h0;
              end else if (c == 7'd1) begin
                snd = 1'b1; snd_nib = dctl_q;
              end else if (c == 7'd2) begin
                cnt_d = '0; seq_d = SeqIdle; done = 1'b1;
              end
            end
          endcase
        end
      end
    end else if (item_i.op == OpInit) begin
      if (idle) begin
        dctl_d = cursor_ctl;
        init_d = 1'b0;
        seq_d  = SeqInit;
        acc    = 1'b1;
      end
    end else if (idle && init_q) begin
      acc = 1'b1;
      case (item_i.op)
        OpLoad: begin
          // stored through the buffer write port
        end
        OpWrite: begin
          tlen_d  = (item_i.length > LenW'(BufChars)) ? LenW'(BufChars) : item_i.length;
          taddr_d = addr;
          wph_d   = 1'b0;
          cpos_d  = '0;
          seq_d   = SeqWrite;
        end
        OpClear: seq_d = SeqClear;
        OpGoto: begin
          taddr_d = addr;
          seq_d   = SeqGoto;
        end
        OpCursor: begin
          dctl_d = cursor_ctl;
          seq_d  = SeqSetup;
        end
        default: begin
          dctl_d = {dctl_q[3], item_i.display_on, dctl_q[1:0]};
          seq_d  = SeqSetup;
        end
      endcase
    end

    rs_d   = snd ? snd_rs : rs_q;
    pins_d = snd ? ~snd_nib : pins_q;
    if (snd) begin
      en_d = 1'b1;
    end
  end

  assign res_o.accepted    = acc;
  assign res_o.busy_res    = (seq_d != SeqIdle);
  assign res_o.initialized = init_d;
  assign res_o.done_res    = done;
  assign res_o.reg_select  = rs_d;
  assign res_o.enable      = en_d && !(seq_d == SeqInit && ph_d == PhSpecial &&
                                       cnt_d == '0);
  assign res_o.data_pins   = pins_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_q <= LinesReset;
      seq_q   <= SeqIdle;
      ph_q    <= PhWait;
      cnt_q   <= '0;
      en_q    <= 1'b0;
      wph_q   <= 1'b0;
      cpos_q  <= '0;
      dctl_q  <= '0;
      init_q  <= 1'b0;
      tlen_q  <= '0;
      taddr_q <= '0;
      rs_q    <= 1'b0;
      pins_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        lines_q <= cfg_data_i;
      end
      if (step_i) begin
        seq_q   <= seq_d;
        ph_q    <= ph_d;
        cnt_q   <= cnt_d;
        en_q    <= en_d;
        wph_q   <= wph_d;
        cpos_q  <= cpos_d;
        dctl_q  <= dctl_d;
        init_q  <= init_d;
        tlen_q  <= tlen_d;
        taddr_q <= taddr_d;
        rs_q    <= rs_d;
        pins_q  <= pins_d;
      end
    end
  end

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |=> seq_q == SeqIdle)
    else $error("done without return to idle");

  a_accept_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && acc |-> seq_q == SeqIdle)
    else $error("command taken while busy");

  a_enable_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && en_q && seq_q != SeqIdle && item_i.op == OpTick |=> !en_q)
    else $error("enable not dropped on tick");

  a_init_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(init_q) |-> $past(seq_q) == SeqInit)
    else $error("initialized set outside init");

endmodule

>>> tb/char_lcd_nibble_sequencer_test.sv
// Self-checking testbench for char_lcd_nibble_sequencer: directed command tests, then
// random command/tick traffic checked against a cycle-free predictor of the sequencer.
// Depends on clns_pkg, clns_ifs and the RTL of the block.
module char_lcd_nibble_sequencer_test;
  import clns_pkg::*;

  localparam int QuietLimit = 500;

  logic clk_i;
  logic rst_ni;

  clns_in_if  in_if ();
  clns_cfg_if cfg_if ();
  clns_out_if out_if ();

  char_lcd_nibble_sequencer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // Predicted sequencer state
  logic [2:0] running;
  logic [2:0] init_stage;
  logic [6:0] step;
  logic       strobe;
  logic       in_text;
  logic [4:0] text_pos;
  logic [4:0] text_len;
  logic [3:0] ctrl_bits;
  logic [3:0] lines_bits;
  logic       init_ok;
  logic [7:0] text_mem [BufChars];
  bit         loaded [BufChars];
  logic [7:0] ddram_addr;
  logic       pin_rs;
  logic [3:0] pin_data;

  out_item_t expected_pins [$];
  int        mismatches;
  int        result_count;
  int        quiet_cycles;
  int        gap_pct;
  bit        calm;
  bit        item_ignored;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void lcd_reset();
    running    = SeqIdle;
    init_stage = PhWait;
    step       = '0;
    strobe     = 1'b0;
    in_text    = 1'b0;
    text_pos   = '0;
    text_len   = '0;
    ctrl_bits  = '0;
    lines_bits = LinesReset;
    init_ok    = 1'b0;
    ddram_addr = '0;
    pin_rs     = 1'b0;
    pin_data   = '0;
    for (int i = 0; i < BufChars; i++) begin
      text_mem[i] = '0;
      loaded[i]   = 1'b0;
    end
  endfunction

  function automatic void drive_nibble(logic rs, logic [3:0] nib);
    pin_rs   = rs;
    pin_data = ~nib;
    strobe   = 1'b1;
  endfunction

  function automatic bit seq_done();
    step    = '0;
    running = SeqIdle;
    return 1'b1;
  endfunction

  function automatic bit init_tick();
    logic [6:0] c;
    if (init_stage == PhWait) begin
      if (step == PowerUpTicks) begin
        // dummy strobe: enable latch goes high but the pin is masked
        step       = '0;
        init_stage = PhSpecial;
        strobe     = 1'b1;
      end else begin
        step = step + 7'd1;
      end
      return 1'b0;
    end
    c    = step;
    step = step + 7'd1;
    case (init_stage)
      PhSpecial: begin
        if (c == 0 || c == 5) drive_nibble(1'b0, 4'h3);
        else if (c == 6) begin
          drive_nibble(1'b0, 4'h3);
          step       = '0;
          init_stage = PhFset;
        end
      end
      PhFset: begin
        if (c == 0 || c == 1) drive_nibble(1'b0, 4'h2);
        else if (c == 2) begin
          drive_nibble(1'b0, lines_bits);
          step       = '0;
          init_stage = PhDisplay;
        end
      end
      PhDisplay: begin
        if (c == 0) drive_nibble(1'b0, 4'h0);
        else if (c == 1) begin
          drive_nibble(1'b0, ctrl_bits);
          step       = '0;
          init_stage = PhClear;
        end
      end
      PhClear: begin
        if (c == 0) drive_nibble(1'b0, 4'h0);
        else if (c == 1) drive_nibble(1'b0, 4'h1);
        else if (c == 3) begin
          step       = '0;
          init_stage = PhEntry;
        end
      end
      default: begin
        if (c == 0) drive_nibble(1'b0, 4'h0);
        else if (c == 1) drive_nibble(1'b0, 4'h6);
        else if (c == 2) begin
          init_stage = PhWait;
          init_ok    = 1'b1;
          return seq_done();
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic bit text_tick();
    logic [6:0] c;
    logic [7:0] ch;
    if (!in_text) begin
      c    = step;
      step = step + 7'd1;
      if (c == 0) drive_nibble(1'b0, ddram_addr[7:4]);
      else if (c == 1) begin
        drive_nibble(1'b0, ddram_addr[3:0]);
        step    = '0;
        in_text = 1'b1;
      end
      return 1'b0;
    end
    if (text_pos >= text_len || text_pos >= BufChars) begin
      in_text  = 1'b0;
      text_pos = '0;
      return seq_done();
    end
    ch   = text_mem[text_pos[3:0]];
    c    = step;
    step = step + 7'd1;
    if (c == 0) drive_nibble(1'b1, ch[7:4]);
    else if (c == 1) begin
      drive_nibble(1'b1, ch[3:0]);
      step     = '0;
      text_pos = text_pos + 5'd1;
    end
    return 1'b0;
  endfunction

  function automatic bit seq_tick();
    logic [6:0] c;
    if (running == SeqIdle) return 1'b0;
    // a high strobe always costs one tick to drop
    if (strobe) begin
      strobe = 1'b0;
      return 1'b0;
    end
    if (running == SeqInit) return init_tick();
    if (running == SeqWrite) return text_tick();
    c    = step;
    step = step + 7'd1;
    case (running)
      SeqClear: begin
        if (c == 0) drive_nibble(1'b0, 4'h0);
        else if (c == 1) drive_nibble(1'b0, 4'h1);
        else if (c == 3) return seq_done();
      end
      SeqGoto: begin
        if (c == 0) drive_nibble(1'b0, ddram_addr[7:4]);
        else if (c == 1) drive_nibble(1'b0, ddram_addr[3:0]);
        else if (c == 2) return seq_done();
      end
      default: begin
        if (c == 0) drive_nibble(1'b0, 4'h0);
        else if (c == 1) drive_nibble(1'b0, ctrl_bits);
        else if (c == 2) return seq_done();
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic [7:0] line_address(in_item_t it);
    return 8'h80 + (it.row ? 8'h40 : 8'h00) + {2'b00, it.column};
  endfunction

  function automatic out_item_t lcd_predict(in_item_t it);
    out_item_t res;
    logic      idle_now;
    idle_now = (running == SeqIdle);
    res      = '0;
    if (it.op == OpTick) begin
      res.done_res = seq_tick();
    end else if (it.op == OpInit) begin
      if (idle_now) begin
        ctrl_bits    = {2'b11, it.cursor_on, it.blink_on};
        init_ok      = 1'b0;
        running      = SeqInit;
        res.accepted = 1'b1;
      end
    end else if (idle_now && init_ok) begin
      res.accepted = 1'b1;
      case (it.op)
        OpLoad: begin
          text_mem[it.char_index] = it.char_code;
          loaded[it.char_index]   = 1'b1;
        end
        OpWrite: begin
          text_len   = (it.length > BufChars) ? LenW'(BufChars) : it.length;
          ddram_addr = line_address(it);
          in_text    = 1'b0;
          text_pos   = '0;
          running    = SeqWrite;
        end
        OpClear: running = SeqClear;
        OpGoto: begin
          ddram_addr = line_address(it);
          running    = SeqGoto;
        end
        OpCursor: begin
          ctrl_bits = {2'b11, it.cursor_on, it.blink_on};
          running   = SeqSetup;
        end
        default: begin
          ctrl_bits = (ctrl_bits & 4'hB) | {1'b0, it.display_on, 2'b00};
          running   = SeqSetup;
        end
      endcase
    end
    res.busy_res    = (running != SeqIdle);
    res.initialized = init_ok;
    res.reg_select  = pin_rs;
    res.enable      = strobe &&
                      !(running == SeqInit && init_stage == PhSpecial && step == 0);
    res.data_pins   = pin_data;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 100) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h want %h", result_count, name, got, want));
  endtask

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_pins.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
      end else begin
        want = expected_pins.pop_front();
        check_field("accepted", 4'(out_if.data.accepted), 4'(want.accepted));
        check_field("busy", 4'(out_if.data.busy_res), 4'(want.busy_res));
        check_field("initialized", 4'(out_if.data.initialized), 4'(want.initialized));
        check_field("done", 4'(out_if.data.done_res), 4'(want.done_res));
        check_field("reg_select", 4'(out_if.data.reg_select), 4'(want.reg_select));
        check_field("enable", 4'(out_if.data.enable), 4'(want.enable));
        check_field("data_pins", out_if.data.data_pins, want.data_pins);
      end
      result_count++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stall bursts, none once the run turns calm
  initial begin : result_taker
    int stall;
    stall        = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (!calm && gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
        stall = $urandom_range(1, 17) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t cmd(logic [2:0] op);
    in_item_t   it;
    logic [31:0] raw;
    raw   = $urandom;
    it    = raw[$bits(in_item_t)-1:0];
    it.op = op;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    out_item_t want;
    logic      idle_before;
    int        k;
    if (!calm && gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    // never let a write read a buffer slot that was never loaded
    if (it.op == OpWrite && running == SeqIdle && init_ok) begin
      k = 0;
      while (k < BufChars && loaded[k]) k++;
      if (k < BufChars && it.length > k) it.length = LenW'(k);
    end
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    idle_before = (running == SeqIdle);
    want        = lcd_predict(it);
    expected_pins.push_back(want);
    item_ignored = (it.op == OpTick) ? idle_before : !want.accepted;
  endtask

  task automatic run_to_idle();
    while (running != SeqIdle) send_item(cmd(OpTick));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_lines(logic [3:0] v);
    wait_drained();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    lines_bits = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_init(logic cur, logic blk);
    in_item_t it;
    it           = cmd(OpInit);
    it.cursor_on = cur;
    it.blink_on  = blk;
    send_item(it);
  endtask

  task automatic send_write(logic row, logic [5:0] col, logic [4:0] len);
    in_item_t it;
    it        = cmd(OpWrite);
    it.row    = row;
    it.column = col;
    it.length = len;
    send_item(it);
    run_to_idle();
  endtask

  // Everything but init is refused before init has completed
  task automatic test_before_init();
    send_item(cmd(OpTick));
    send_item(cmd(OpLoad));
    send_item(cmd(OpWrite));
    send_item(cmd(OpDisplay));
  endtask

  task automatic test_init_sequence();
    set_lines(4'hF);
    send_init(1'b1, 1'b0);
    // commands while busy are dropped, init included
    send_item(cmd(OpInit));
    send_item(cmd(OpClear));
    run_to_idle();
    send_item(cmd(OpTick));
  endtask

  task automatic test_load_buffer();
    in_item_t it;
    for (int i = 0; i < BufChars; i++) begin
      it            = cmd(OpLoad);
      it.char_index = 4'(i);
      if (i == 0) it.char_code = 8'h00;
      else if (i == 1) it.char_code = 8'hFF;
      send_item(it);
    end
  endtask

  task automatic test_write_text();
    send_write(1'b0, 6'd0, 5'd0);
    send_write(1'b1, 6'd63, 5'd16);
    send_write(1'b0, 6'd21, 5'd31);  // saturates to the full buffer
  endtask

  task automatic test_clear_goto();
    send_item(cmd(OpClear));
    run_to_idle();
    send_write(1'b1, 6'd0, 5'd1);
    send_item(cmd(OpGoto));
    run_to_idle();
  endtask

  task automatic test_display_control();
    in_item_t it;
    send_init(1'b1, 1'b1);
    run_to_idle();
    it            = cmd(OpDisplay);
    it.display_on = 1'b0;
    send_item(it);
    run_to_idle();
    it.display_on = 1'b1;
    send_item(it);
    run_to_idle();
    it           = cmd(OpCursor);
    it.cursor_on = 1'b0;
    it.blink_on  = 1'b0;
    send_item(it);
    run_to_idle();
  endtask

  task automatic test_reinit();
    set_lines(4'h0);
    send_init(1'b0, 1'b1);
    run_to_idle();
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    it = cmd(OpTick);
    it.op = 3'($urandom_range(0, 7));
    r  = $urandom_range(0, 99);
    if (running != SeqIdle) begin
      if (r < 90) it.op = OpTick;
    end else if (!init_ok) begin
      if (r < 70) it.op = OpInit;
    end else if (r < 3)  it.op = OpInit;
    else if (r < 10) it.op = OpTick;
    else if (r < 30) it.op = OpLoad;
    else if (r < 50) it.op = OpWrite;
    else if (r < 60) it.op = OpClear;
    else if (r < 72) it.op = OpGoto;
    else if (r < 86) it.op = OpCursor;
    else it.op = OpDisplay;
    return it;
  endfunction

  task automatic test_random_traffic();
    int counted;
    int ph;
    for (ph = 0; ph < 4; ph++) begin
      run_to_idle();
      case (ph)
        0: set_lines(4'h0);
        1: set_lines(4'hF);
        default: set_lines(4'($urandom_range(0, 15)));
      endcase
      gap_pct = (ph == 1) ? 0 : (ph == 2) ? 30 : 12;
      calm    = (ph == 3);
      counted = 0;
      while (counted < 230) begin
        send_item(random_item());
        if (!item_ignored) counted++;
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    mismatches   = 0;
    result_count = 0;
    quiet_cycles = 0;
    gap_pct      = 10;
    calm         = 1'b0;
    item_ignored = 1'b0;
    lcd_reset();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_before_init();
    test_init_sequence();
    test_load_buffer();
    test_write_text();
    test_clear_goto();
    test_display_control();
    test_reinit();
    test_random_traffic();

    run_to_idle();
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
